/* sv/iem_pkg.sv */
// Shared types and constants for the ICMP echo reply matcher.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package iem_pkg;

   localparam int DEFAULT_MAX_FRAME_BYTES = 2048;

   localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP      = 8'd1;
   localparam logic [7:0]  TYPE_ECHO_REPLY = 8'd0;
   localparam int          MAC_BYTES       = 6;

   localparam int          MAC_FIRST      = 6;
   localparam int          ETHERTYPE_POS  = 12;
   localparam int          IP_START       = 14;
   localparam int          PROTO_POS      = 23;
   localparam logic [3:0]  MIN_IHL        = 4'd5;

   localparam int MAC_WIDTH = 8 * MAC_BYTES;

   // progress of the two identifier bytes
   typedef enum logic [1:0] {
      ID_NONE = 2'd0,
      ID_HIGH = 2'd1,
      ID_BOTH = 2'd2
   } iem_id_type;

   typedef struct packed {
      logic                 matched;
      logic [MAC_WIDTH-1:0] mac;
   } iem_result_type;

endpackage

`default_nettype wire

/* sv/iem_channels.sv */
// Valid/ready channel interfaces: frame bytes in, match results out, CSR writes.
// Depends on iem_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface iem_req_if import iem_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface iem_rsp_if import iem_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 reply_matched;
   logic [MAC_WIDTH-1:0] sender_mac;

   modport source (output valid, output reply_matched, output sender_mac, input ready);
   modport sink   (input valid, input reply_matched, input sender_mac, output ready);
endinterface

interface iem_csr_if import iem_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [15:0] echo_identifier;

   modport source (output valid, output echo_identifier, input ready);
   modport sink   (input valid, input echo_identifier, output ready);
endinterface

`default_nettype wire

/* sv/iem_frame_parser.sv */
// Per-frame state: byte counter, source MAC capture and header checks.
// Depends on iem_pkg. Produces the verdict on the last word of a frame.
`timescale 1ns / 1ps
`default_nettype none

module iem_frame_parser import iem_pkg::*; #(
   parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire logic [7:0]     frame_byte,
   input  wire logic           frame_end,
   input  wire logic [15:0]    echo_identifier,
   output iem_result_type      result
);

   localparam int PW = $clog2(MAX_FRAME_BYTES);
   // compare width: the ICMP offsets reach 79, so at least 8 bits
   localparam int CW = (PW > 8) ? PW : 8;
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_FRAME_BYTES - 1);

   logic [PW-1:0]        pos_ff, pos_in;
   logic [MAC_WIDTH-1:0] mac_ff, mac_in;
   logic                 eth_hi_ff, eth_hi_in;
   logic                 eth_ok_ff, eth_ok_in;
   logic [3:0]           hw_ff, hw_in;
   logic                 proto_ff, proto_in;
   logic                 type_ff, type_in;
   iem_id_type           id_ff, id_in;

   logic [CW-1:0] posx;
   logic [CW-1:0] icmp_pos;
   logic          hdr_ok;

   assign posx     = CW'(pos_ff);
   assign icmp_pos = CW'(IP_START) + CW'({hw_ff, 2'b00});
   assign hdr_ok   = (hw_ff >= MIN_IHL);

   always_comb begin
      pos_in    = pos_ff;
      mac_in    = mac_ff;
      eth_hi_in = eth_hi_ff;
      eth_ok_in = eth_ok_ff;
      hw_in     = hw_ff;
      proto_in  = proto_ff;
      type_in   = type_ff;
      id_in     = id_ff;
      result    = '0;

      if (in_valid && (pos_ff != POS_LAST)) begin
         pos_in = pos_ff + PW'(1);
         if (posx >= CW'(MAC_FIRST) && posx < CW'(MAC_FIRST + MAC_BYTES)) begin
            mac_in = {mac_ff[MAC_WIDTH-9:0], frame_byte};
         end
         if (posx == CW'(ETHERTYPE_POS)) begin
            eth_hi_in = (frame_byte == ETHERTYPE_IPV4[15:8]);
         end
         if (posx == CW'(ETHERTYPE_POS + 1)) begin
            eth_ok_in = eth_hi_ff && (frame_byte == ETHERTYPE_IPV4[7:0]);
         end
         if (posx == CW'(IP_START)) begin
            hw_in = frame_byte[3:0];
         end
         if (posx == CW'(PROTO_POS)) begin
            proto_in = (frame_byte == PROTO_ICMP);
         end
         if (hdr_ok) begin
            if (posx == icmp_pos) begin
               type_in = (frame_byte == TYPE_ECHO_REPLY);
            end
            if (posx == icmp_pos + CW'(4)) begin
               id_in = (frame_byte == echo_identifier[15:8]) ? ID_HIGH : ID_NONE;
            end
            if (posx == icmp_pos + CW'(5)) begin
               id_in = (id_ff == ID_HIGH && frame_byte == echo_identifier[7:0])
                       ? ID_BOTH : ID_NONE;
            end
         end
      end

      if (in_valid && frame_end) begin
         result.matched = eth_ok_in && proto_in && (hw_in >= MIN_IHL) && type_in &&
                          (id_in == ID_BOTH);
         result.mac     = result.matched ? mac_in : '0;
         pos_in    = '0;
         mac_in    = '0;
         eth_hi_in = 1'b0;
         eth_ok_in = 1'b0;
         hw_in     = '0;
         proto_in  = 1'b0;
         type_in   = 1'b0;
         id_in     = ID_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         mac_ff    <= '0;
         eth_hi_ff <= 1'b0;
         eth_ok_ff <= 1'b0;
         hw_ff     <= '0;
         proto_ff  <= 1'b0;
         type_ff   <= 1'b0;
         id_ff     <= ID_NONE;
      end else begin
         pos_ff    <= pos_in;
         mac_ff    <= mac_in;
         eth_hi_ff <= eth_hi_in;
         eth_ok_ff <= eth_ok_in;
         hw_ff     <= hw_in;
         proto_ff  <= proto_in;
         type_ff   <= type_in;
         id_ff     <= id_in;
      end
   end

endmodule

`default_nettype wire

/* sv/icmp_echo_reply_matcher_core.sv */
// ICMP echo reply matcher, top level.
// Frame words (one byte each) enter on req_bus with an end-of-frame mark.
// For every word carrying frame_end one result word leaves on rsp_bus:
// reply_matched and the sender MAC (zero unless matched).
// Checks: ethertype IPv4, protocol ICMP, ICMP type echo reply at the offset
// given by the IHL, identifier equal to the CSR value.
// csr_bus writes the 16-bit expected identifier; always ready, write only
// while no frame is in progress.
// Throughput: one byte per clock. Latency: the result is registered and is
// valid the cycle after the last byte is accepted.
// The frame state is updated straight from the accepted byte; the result
// register is the only stage. req_bus.ready drops only while a result is
// held and rsp_bus.ready is low; then the next byte waits.
// Bytes from position MAX_FRAME_BYTES - 1 on are neither counted nor examined.
// Reset (synchronous) clears frame state and the result valid flag and sets
// the identifier to zero; the result data register is not reset.
// Depends on iem_pkg, iem_channels and iem_frame_parser.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_reply_matcher_core import iem_pkg::*; #(
   parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
   input  wire logic clock,
   input  wire logic reset,
   iem_req_if.sink   req_bus,
   iem_rsp_if.source rsp_bus,
   iem_csr_if.sink   csr_bus
);

   logic [15:0]    ident_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   iem_result_type rsp_ff;
   iem_result_type verdict;
   logic           accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   iem_frame_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .frame_byte      (req_bus.frame_byte),
      .frame_end       (req_bus.frame_end),
      .echo_identifier (ident_ff),
      .result          (verdict)
   );

   always_comb begin
      if (accept && req_bus.frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ident_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            ident_ff <= csr_bus.echo_identifier;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_bus.frame_end) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.reply_matched = rsp_ff.matched;
   assign rsp_bus.sender_mac    = rsp_ff.mac;

endmodule

`default_nettype wire

/* tb/sv/iem_reply_checker.sv */
`timescale 1ns / 1ps
// Checker for the ICMP echo reply matcher: watches the frame, result and CSR
// channels, predicts every result word and compares it field by field.
// Depends on iem_pkg and iem_channels.
module iem_reply_checker import iem_pkg::*; #(
   parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
   input  logic clock,
   input  logic reset,
   iem_req_if   req_bus,
   iem_rsp_if   rsp_bus,
   iem_csr_if   csr_bus,
   output int   error_count,
   output int   pending_results
);

   logic [15:0]          echo_id;
   int                   byte_pos;
   logic [MAC_WIDTH-1:0] src_mac;
   logic                 eth_high_ok;
   logic                 eth_ok;
   logic                 proto_ok;
   logic                 type_ok;
   logic [3:0]           ihl;
   iem_id_type           id_progress;
   iem_result_type       expected_replies[$];

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic clear_frame();
      byte_pos    = 0;
      src_mac     = '0;
      eth_high_ok = 1'b0;
      eth_ok      = 1'b0;
      proto_ok    = 1'b0;
      type_ok     = 1'b0;
      ihl         = '0;
      id_progress = ID_NONE;
   endtask

   // one frame word: update the match flags, and on the last word queue the verdict
   task automatic take_frame_byte(input logic [7:0] value, input logic last);
      int             icmp_at;
      iem_result_type want;
      if (byte_pos < MAX_FRAME_BYTES - 1) begin
         if (byte_pos >= MAC_FIRST && byte_pos < MAC_FIRST + MAC_BYTES)
            src_mac = {src_mac[MAC_WIDTH-9:0], value};
         if (byte_pos == ETHERTYPE_POS)
            eth_high_ok = (value == ETHERTYPE_IPV4[15:8]);
         if (byte_pos == ETHERTYPE_POS + 1)
            eth_ok = eth_high_ok && (value == ETHERTYPE_IPV4[7:0]);
         if (byte_pos == IP_START)
            ihl = value[3:0];
         if (byte_pos == PROTO_POS)
            proto_ok = (value == PROTO_ICMP);
         // a header length below the minimum locates no ICMP header at all
         if (ihl >= MIN_IHL) begin
            icmp_at = IP_START + 4 * int'(ihl);
            if (byte_pos == icmp_at)
               type_ok = (value == TYPE_ECHO_REPLY);
            if (byte_pos == icmp_at + 4)
               id_progress = (value == echo_id[15:8]) ? ID_HIGH : ID_NONE;
            if (byte_pos == icmp_at + 5)
               id_progress = (id_progress == ID_HIGH && value == echo_id[7:0]) ?
                             ID_BOTH : ID_NONE;
         end
         byte_pos++;
      end
      if (last) begin
         want.matched = eth_ok && proto_ok && ihl >= MIN_IHL && type_ok &&
                        id_progress == ID_BOTH;
         want.mac     = want.matched ? src_mac : '0;
         expected_replies.push_back(want);
         clear_frame();
      end
   endtask

   task automatic check_reply(input logic matched, input logic [MAC_WIDTH-1:0] mac);
      iem_result_type want;
      if (expected_replies.size() == 0) begin
         report_mismatch($sformatf("result word with no frame end pending (matched %b mac %h)",
                                   matched, mac));
         return;
      end
      want = expected_replies.pop_front();
      if (matched !== want.matched)
         report_mismatch($sformatf("reply_matched %b, expected %b", matched, want.matched));
      if (mac !== want.mac)
         report_mismatch($sformatf("sender_mac %h, expected %h", mac, want.mac));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         echo_id = '0;
         clear_frame();
         expected_replies.delete();
         error_count = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready)
            echo_id = csr_bus.echo_identifier;
         if (rsp_bus.valid && rsp_bus.ready)
            check_reply(rsp_bus.reply_matched, rsp_bus.sender_mac);
         if (req_bus.valid && req_bus.ready)
            take_frame_byte(req_bus.frame_byte, req_bus.frame_end);
      end
      pending_results <= expected_replies.size();
   end

endmodule

/* tb/sv/icmp_echo_reply_matcher_core_test.sv */
`timescale 1ns / 1ps
// Top of the ICMP echo reply matcher bench: directed frames, then random
// frames with idle gaps and stalls; the checker does prediction and compare.
// Depends on iem_pkg, iem_channels, icmp_echo_reply_matcher_core, iem_reply_checker.
module icmp_echo_reply_matcher_core_test;
   import iem_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   // random phase; the directed frames add about 600 words more
   localparam int RANDOM_WORDS = 1300;
   // small frame limit so that long frames reach the saturation point quickly
   localparam int TB_MAX_FRAME_BYTES = 256;

   typedef logic [7:0] octet_queue_type[$];

   // what is wrong with a generated echo reply
   typedef enum int {
      FLAW_NONE,
      FLAW_ETH_HI,
      FLAW_ETH_LO,
      FLAW_PROTO,
      FLAW_TYPE,
      FLAW_ID_HI,
      FLAW_ID_LO,
      FLAW_SHORT_HDR,
      FLAW_TRUNCATED
   } flaw_type;

   logic        clock;
   logic        reset;
   int          error_count;
   int          pending_results;
   int          cycle_count;
   int          ready_hold;
   bit          sender_gaps;
   bit          sink_stalls;
   logic [15:0] active_id;

   iem_req_if req_bus();
   iem_rsp_if rsp_bus();
   iem_csr_if csr_bus();

   icmp_echo_reply_matcher_core #(
      .MAX_FRAME_BYTES(TB_MAX_FRAME_BYTES)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   iem_reply_checker #(
      .MAX_FRAME_BYTES(TB_MAX_FRAME_BYTES)
   ) reply_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: bursts of ready, short stalls, now and then a long one
   always @(posedge clock) begin
      int roll;
      roll = $urandom_range(0, 99);
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (!sink_stalls || roll < 55) begin
         rsp_bus.ready <= 1'b1;
         ready_hold    <= sink_stalls ? $urandom_range(0, 6) : 0;
      end else if (roll < 92) begin
         rsp_bus.ready <= 1'b0;
         ready_hold    <= $urandom_range(0, 3);
      end else begin
         rsp_bus.ready <= 1'b0;
         ready_hold    <= $urandom_range(8, 40);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!sender_gaps || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [MAC_WIDTH-1:0] random_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // echo reply frame with random filler, optionally spoiled in one place
   function automatic octet_queue_type build_reply(input flaw_type flaw,
                                                   input logic [3:0] hdr_len,
                                                   input logic [15:0] id,
                                                   input logic [MAC_WIDTH-1:0] mac,
                                                   input int tail);
      octet_queue_type f;
      int     words;
      int     icmp_at;
      words   = (hdr_len < MIN_IHL) ? int'(MIN_IHL) : int'(hdr_len);
      icmp_at = IP_START + 4 * words;
      for (int i = 0; i < icmp_at + 8 + tail; i++)
         f.push_back(8'($urandom));
      for (int i = 0; i < MAC_BYTES; i++)
         f[MAC_FIRST + i] = mac[MAC_WIDTH - 1 - 8 * i -: 8];
      f[ETHERTYPE_POS]     = ETHERTYPE_IPV4[15:8];
      f[ETHERTYPE_POS + 1] = ETHERTYPE_IPV4[7:0];
      // version nibble is not checked, so vary it now and then
      f[IP_START]   = {($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4, hdr_len};
      f[PROTO_POS]  = PROTO_ICMP;
      f[icmp_at]    = TYPE_ECHO_REPLY;
      f[icmp_at + 4] = id[15:8];
      f[icmp_at + 5] = id[7:0];
      case (flaw)
         FLAW_ETH_HI:    f[ETHERTYPE_POS]     ^= 8'($urandom_range(1, 255));
         FLAW_ETH_LO:    f[ETHERTYPE_POS + 1] ^= 8'($urandom_range(1, 255));
         FLAW_PROTO:     f[PROTO_POS]         ^= 8'($urandom_range(1, 255));
         FLAW_TYPE:      f[icmp_at]           ^= 8'($urandom_range(1, 255));
         FLAW_ID_HI:     f[icmp_at + 4]       ^= 8'($urandom_range(1, 255));
         FLAW_ID_LO:     f[icmp_at + 5]       ^= 8'($urandom_range(1, 255));
         FLAW_SHORT_HDR: f[IP_START] = {f[IP_START][7:4], 4'($urandom_range(0, 4))};
         FLAW_TRUNCATED: f = f[0 : $urandom_range(0, icmp_at + 4)];
         default: ;
      endcase
      return f;
   endfunction

   // returns at the accepting edge; the next call drives valid in that same step
   task automatic send_word(input logic [7:0] value, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.frame_byte <= value;
      req_bus.frame_end  <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_frame(input octet_queue_type f);
      foreach (f[i])
         send_word(f[i], i == f.size() - 1);
   endtask

   // hold the sender until every result is back, then let the pipe settle
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_echo_id(input logic [15:0] id);
      drain_results();
      csr_bus.valid           <= 1'b1;
      csr_bus.echo_identifier <= id;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      active_id = id;
   endtask

   initial begin
      octet_queue_type f;
      int          budget;
      int          frame_no;
      int          roll;
      logic [3:0]  hdr_len;

      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.frame_byte      = '0;
      req_bus.frame_end       = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.echo_identifier = '0;
      sender_gaps             = 1'b1;
      sink_stalls             = 1'b1;
      active_id               = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: identifier from reset, both identifier extremes, every flaw
      send_frame(build_reply(FLAW_NONE, 4'd5, 16'h0000, '1, 0));
      write_echo_id(16'hFFFF);
      send_frame(build_reply(FLAW_NONE, 4'd15, 16'hFFFF, '0, 3));
      write_echo_id(16'hA55A);
      for (int k = FLAW_ETH_HI; k <= FLAW_TRUNCATED; k++)
         send_frame(build_reply(flaw_type'(k), 4'd6, 16'hA55A, random_mac(), 2));
      // frame ends on the upper identifier word
      f = build_reply(FLAW_NONE, 4'd5, 16'hA55A, random_mac(), 0);
      f = f[0 : IP_START + 4 * int'(MIN_IHL) + 4];
      send_frame(f);
      f.delete();
      f.push_back(8'h45);
      send_frame(f);
      send_frame(build_reply(FLAW_NONE, 4'd5, 16'hA55A, random_mac(), 1));

      budget   = 0;
      frame_no = 0;
      while (budget < RANDOM_WORDS) begin
         if (frame_no % 6 == 5) begin
            roll = $urandom_range(0, 3);
            write_echo_id(roll == 0 ? 16'h0000 : roll == 1 ? 16'hFFFF : 16'($urandom));
            sender_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
         end
         hdr_len = $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(5, 15));
         if (frame_no == 2 || frame_no == 8) begin
            // long frame: runs past the saturation point of the position count
            f = build_reply(FLAW_NONE, 4'd5, active_id, random_mac(),
                            $urandom_range(TB_MAX_FRAME_BYTES - 40, TB_MAX_FRAME_BYTES + 20));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               f = build_reply(FLAW_NONE, hdr_len, active_id, random_mac(),
                               $urandom_range(0, 24));
            end else if (roll < 80) begin
               f = build_reply(flaw_type'($urandom_range(FLAW_ETH_HI, FLAW_TRUNCATED)),
                               hdr_len, active_id, random_mac(), $urandom_range(0, 24));
            end else if (roll < 92) begin
               f.delete();
               repeat ($urandom_range(1, 40)) f.push_back(8'($urandom));
            end else begin
               f = build_reply(FLAW_NONE, hdr_len, 16'($urandom), random_mac(),
                               $urandom_range(0, 24));
            end
         end
         send_frame(f);
         budget += f.size();
         frame_no++;
      end

      drain_results();
      if (error_count == 0 && pending_results == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
